/* rtl/core/lkr_pkg.sv */
// Shared types and constants for the LRU-K frame replacer.
// Holds operation codes, status codes, sequencer states and fixed field widths.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lkr_pkg;

    localparam int FUNC_W      = 2;
    localparam int FRAME_W     = 6;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int KTH_W       = 4;
    localparam int HIT_W       = 4;
    localparam int INDEX_EXT_W = 11;

    localparam logic [HIT_W-1:0] HIT_MAX = 4'd15;
    localparam logic [HIT_W-1:0] HIT_ONE = 4'd1;
    localparam logic [KTH_W-1:0] KTH_RESET = 4'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACCESS    = 2'd0,
        FUNC_SET_EVICT = 2'd1,
        FUNC_REMOVE    = 2'd2,
        FUNC_EVICT     = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_VICTIM    = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2,
        STATUS_PINNED       = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_PICK = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/lru_k_frame_replacer.sv */
// Top level of the LRU-K frame replacer: frame bookkeeping, stamp memory and evict scan.
// Depends on lkr_pkg for codes, states and field widths.
//
// Usage: an operation is taken at a rising edge where start is high and busy is low;
// func, frame and evictable_value are sampled with it, and the hit-count memory is read
// at that same edge. Access, set evictable and remove keep busy high for one cycle, in
// which the change is applied. The result beat (status, victim_frame, evictable_count)
// is shown with done high for exactly one cycle, the cycle after busy falls, and a new
// start is taken in that cycle. An evict keeps busy high through the serial scan of
// the stamp memory: one frame is read per cycle, then the read pipeline drains and the
// pick state untracks the victim. One compare per class keeps the best young and the
// best mature candidate. Its result beat follows once busy falls.
// The receiver of results cannot stall, so a result is never held. The k_threshold
// register is written through cfg_valid, which is always ready, and should only be
// written while busy is low.
// Reset clears the tracking flags, the stamp counter, the evictable total and the
// sequencer, and loads k_threshold with 2; no clearing pass is needed, as the contents
// of the stamp and hit-count memories are only used for tracked frames.
`timescale 1ns / 1ps
`default_nettype none

module lru_k_frame_replacer #(
    parameter int FRAMES     = 64,
    parameter int STAMP_BITS = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lkr_pkg::FUNC_W-1:0]    func,
    input  wire logic [lkr_pkg::FRAME_W-1:0]   frame,
    input  wire logic                          evictable_value,
    output logic                               done,
    output logic [lkr_pkg::STATUS_W-1:0]       status,
    output logic [lkr_pkg::FRAME_W-1:0]        victim_frame,
    output logic [lkr_pkg::COUNT_W-1:0]        evictable_count,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lkr_pkg::KTH_W-1:0]     cfg_data
);
    import lkr_pkg::*;

    localparam int IDX_W = $clog2(FRAMES);
    localparam int CNT_W = $clog2(FRAMES + 1);

    state_t                  state_reg;
    func_t                   op_reg;
    logic [IDX_W-1:0]        fidx_reg;
    logic                    frange_reg;
    logic                    ev_reg;

    logic [HIT_W-1:0]        hit_mem [FRAMES];
    logic [STAMP_BITS-1:0]   stamp_mem [FRAMES];
    logic [HIT_W-1:0]        hc_rd_reg;
    logic [STAMP_BITS-1:0]   stamp_rd_reg;

    logic [FRAMES-1:0]       tracked_reg;
    logic [FRAMES-1:0]       mature_reg;
    logic [FRAMES-1:0]       canev_reg;
    logic [STAMP_BITS-1:0]   stamp_cnt_reg;
    logic [COUNT_W-1:0]      total_reg;
    logic [KTH_W-1:0]        kth_reg;

    logic [CNT_W-1:0]        scan_cnt_reg;
    logic                    p_vld_reg;
    logic                    p_mat_reg;
    logic [IDX_W-1:0]        p_idx_reg;
    logic                    by_vld_reg;
    logic [STAMP_BITS-1:0]   by_stamp_reg;
    logic [IDX_W-1:0]        by_idx_reg;
    logic                    bm_vld_reg;
    logic [STAMP_BITS-1:0]   bm_stamp_reg;
    logic [IDX_W-1:0]        bm_idx_reg;

    logic                    done_reg;
    status_t                 status_reg;
    logic [FRAME_W-1:0]      victim_reg;

    logic [INDEX_EXT_W-1:0]  frame_ext;
    logic [IDX_W-1:0]        frame_idx;
    logic                    frame_in_range;
    logic [IDX_W-1:0]        scan_idx;
    logic                    scan_end;
    logic [HIT_W-1:0]        hc_inc;
    logic                    to_mature;
    logic                    acc;
    logic                    hit_we;
    logic [HIT_W-1:0]        hit_wdata;
    logic                    stamp_we;
    logic                    p_beats_y;
    logic                    p_beats_m;
    logic                    pick_vld;
    logic [IDX_W-1:0]        pick_idx;
    logic [INDEX_EXT_W-1:0]  pick_ext;
    logic [COUNT_W-1:0]      tot_dec;

    assign frame_ext      = INDEX_EXT_W'(frame);
    assign frame_idx      = frame_ext[IDX_W-1:0];
    assign frame_in_range = frame_ext < INDEX_EXT_W'(FRAMES);
    assign scan_idx       = scan_cnt_reg[IDX_W-1:0];
    assign scan_end       = scan_cnt_reg == CNT_W'(FRAMES);

    always_comb
    begin
        hc_inc    = (hc_rd_reg < HIT_MAX) ? hc_rd_reg + HIT_ONE : hc_rd_reg;
        to_mature = hc_inc >= kth_reg;
        acc       = (state_reg == S_EXEC) && frange_reg && (op_reg == FUNC_ACCESS);
        hit_we    = acc && !mature_reg[fidx_reg];
        hit_wdata = tracked_reg[fidx_reg] ? hc_inc : HIT_ONE;
        stamp_we  = acc && (!tracked_reg[fidx_reg] || mature_reg[fidx_reg] || to_mature);
        p_beats_y = p_vld_reg && !p_mat_reg && (!by_vld_reg || stamp_rd_reg < by_stamp_reg);
        p_beats_m = p_vld_reg && p_mat_reg && (!bm_vld_reg || stamp_rd_reg < bm_stamp_reg);
        pick_vld  = by_vld_reg || bm_vld_reg;
        pick_idx  = by_vld_reg ? by_idx_reg : bm_idx_reg;
        pick_ext  = INDEX_EXT_W'(pick_idx);
        tot_dec   = (total_reg != '0) ? total_reg - COUNT_W'(1) : total_reg;
    end

    // Hit-count and stamp memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            hc_rd_reg <= hit_mem[frame_idx];
        end
        stamp_rd_reg <= stamp_mem[scan_idx];
        if (hit_we)
        begin
            hit_mem[fidx_reg] <= hit_wdata;
        end
        if (stamp_we)
        begin
            stamp_mem[fidx_reg] <= stamp_cnt_reg;
        end
    end

    // Evict scan datapath; candidate payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN)
        begin
            p_mat_reg <= mature_reg[scan_idx];
            p_idx_reg <= scan_idx;
            if (p_beats_y)
            begin
                by_stamp_reg <= stamp_rd_reg;
                by_idx_reg   <= p_idx_reg;
            end
            if (p_beats_m)
            begin
                bm_stamp_reg <= stamp_rd_reg;
                bm_idx_reg   <= p_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= FUNC_ACCESS;
            fidx_reg      <= '0;
            frange_reg    <= 1'b0;
            ev_reg        <= 1'b0;
            tracked_reg   <= '0;
            mature_reg    <= '0;
            canev_reg     <= '0;
            stamp_cnt_reg <= '0;
            total_reg     <= '0;
            kth_reg       <= KTH_RESET;
            scan_cnt_reg  <= '0;
            p_vld_reg     <= 1'b0;
            by_vld_reg    <= 1'b0;
            bm_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= STATUS_OK;
            victim_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                kth_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= func_t'(func);
                        fidx_reg   <= frame_idx;
                        frange_reg <= frame_in_range;
                        ev_reg     <= evictable_value;
                        if (func_t'(func) == FUNC_EVICT)
                        begin
                            scan_cnt_reg <= '0;
                            p_vld_reg    <= 1'b0;
                            by_vld_reg   <= 1'b0;
                            bm_vld_reg   <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC:
                begin
                    done_reg   <= 1'b1;
                    victim_reg <= '0;
                    status_reg <= STATUS_OK;
                    state_reg  <= S_IDLE;
                    if (stamp_we)
                    begin
                        stamp_cnt_reg <= stamp_cnt_reg + STAMP_BITS'(1);
                    end
                    if (!frange_reg)
                    begin
                        status_reg <= STATUS_OUT_OF_RANGE;
                    end
                    else
                    begin
                        case (op_reg)
                            FUNC_ACCESS:
                            begin
                                if (!tracked_reg[fidx_reg])
                                begin
                                    tracked_reg[fidx_reg] <= 1'b1;
                                    mature_reg[fidx_reg]  <= 1'b0;
                                    canev_reg[fidx_reg]   <= 1'b1;
                                    total_reg             <= total_reg + COUNT_W'(1);
                                end
                                else if (!mature_reg[fidx_reg] && to_mature)
                                begin
                                    mature_reg[fidx_reg] <= 1'b1;
                                end
                            end
                            FUNC_SET_EVICT:
                            begin
                                if (tracked_reg[fidx_reg] && canev_reg[fidx_reg] != ev_reg)
                                begin
                                    canev_reg[fidx_reg] <= ev_reg;
                                    total_reg <= ev_reg ? total_reg + COUNT_W'(1) : tot_dec;
                                end
                            end
                            FUNC_REMOVE:
                            begin
                                if (tracked_reg[fidx_reg])
                                begin
                                    if (!canev_reg[fidx_reg])
                                    begin
                                        status_reg <= STATUS_PINNED;
                                    end
                                    else
                                    begin
                                        tracked_reg[fidx_reg] <= 1'b0;
                                        mature_reg[fidx_reg]  <= 1'b0;
                                        canev_reg[fidx_reg]   <= 1'b0;
                                        total_reg             <= tot_dec;
                                    end
                                end
                            end
                            default:
                            begin
                                status_reg <= STATUS_OK;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (p_beats_y)
                    begin
                        by_vld_reg <= 1'b1;
                    end
                    if (p_beats_m)
                    begin
                        bm_vld_reg <= 1'b1;
                    end
                    if (scan_end)
                    begin
                        p_vld_reg <= 1'b0;
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        p_vld_reg    <= tracked_reg[scan_idx] && canev_reg[scan_idx];
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    end
                end
                S_PICK:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    if (pick_vld)
                    begin
                        status_reg            <= STATUS_OK;
                        victim_reg            <= pick_ext[FRAME_W-1:0];
                        tracked_reg[pick_idx] <= 1'b0;
                        mature_reg[pick_idx]  <= 1'b0;
                        canev_reg[pick_idx]   <= 1'b0;
                        total_reg             <= tot_dec;
                    end
                    else
                    begin
                        status_reg <= STATUS_NO_VICTIM;
                        victim_reg <= '0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = done_reg;
    assign status          = status_reg;
    assign victim_frame    = victim_reg;
    assign evictable_count = total_reg;
    assign cfg_ready       = 1'b1;

    // An accepted operation always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("block not busy after accepting an operation");

    // A result beat is only shown once the sequencer has returned to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while still busy");

    // The evictable total can never exceed the number of frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        INDEX_EXT_W'(total_reg) <= INDEX_EXT_W'(FRAMES))
        else $error("evictable total exceeds frame count");

    // A successful eviction untracks the frame it reports.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK && pick_vld) |=> !tracked_reg[$past(pick_idx)])
        else $error("evicted frame still tracked");

endmodule

`default_nettype wire
